[src/mcst_pkg.sv]
// Package: shared types, stage counts and saturation helper for the swept circle test.
`default_nettype none
package mcst_pkg;

  // Iteration counts of the pipelined root and divide sections
  localparam int SQ1_STEPS = 64;  // root of the 128-bit discriminant
  localparam int TD_STEPS  = 31;  // impact time quotient bits
  localparam int CS_STEPS  = 33;  // contact quotient bits and normal length root bits
  localparam int ND_STEPS  = 17;  // normal quotient bits

  // Circle geometry carried down the pipe
  typedef struct packed {
    logic signed [31:0] pax;
    logic signed [31:0] pay;
    logic signed [31:0] pbx;
    logic signed [31:0] pby;
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic [30:0]        ra;
    logic [31:0]        rab;
  } geom_t;

  // Carry through the discriminant and its square root
  typedef struct packed {
    geom_t       g;
    logic [63:0] a;
    logic        hneg;
    logic [63:0] hmag;
    logic        ge;
    logic        hit;
  } hcar_t;

  // Carry through the impact time divider
  typedef struct packed {
    geom_t       g;
    logic [63:0] a;
    logic        ovf;
    logic        hit;
  } dcar_t;

  // Carry through the contact divider and normal length root
  typedef struct packed {
    logic signed [31:0] qax;
    logic signed [31:0] qay;
    logic               negx;   // dx < 0
    logic               negy;
    logic               nnegx;  // dx > 0: normal x points negative
    logic               nnegy;
    logic [32:0]        mx;     // |dx|
    logic [32:0]        my;
    logic [31:0]        den;
    logic [30:0]        t;
    logic               hit;
  } ccar_t;

  // Carry through the normal divider
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               nnegx;
    logic               nnegy;
    logic [32:0]        den;
    logic [30:0]        t;
    logic               hit;
  } ncar_t;

  // Clamp a signed value to the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(x[31:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/moving_circle_sweep_test_core.sv]
// Top level: fully pipelined swept circle-circle collision time, contact point and normal.
// Throughput: one request per cycle; the whole pipe advances unless the output is stalled.
// Depth is set by the bit-per-stage discriminant root (64 stages), the time divider
// (31 stages), the contact divider with the normal length root (33) and the normal divider (17).
// Reset: synchronous, clears all valid bits; payload registers are not reset.
`default_nettype none
module moving_circle_sweep_test_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_a_x,
  input  logic signed [31:0] pos_a_y,
  input  logic signed [31:0] vel_a_x,
  input  logic signed [31:0] vel_a_y,
  input  logic [30:0]        radius_a,
  input  logic signed [31:0] pos_b_x,
  input  logic signed [31:0] pos_b_y,
  input  logic signed [31:0] vel_b_x,
  input  logic signed [31:0] vel_b_y,
  input  logic [30:0]        radius_b,
  input  logic [20:0]        step_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [30:0]        impact_time,
  output logic signed [31:0] contact_x,
  output logic signed [31:0] contact_y,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y
);

  localparam int Q1N = mcst_pkg::SQ1_STEPS;
  localparam int TDN = mcst_pkg::TD_STEPS;
  localparam int CSN = mcst_pkg::CS_STEPS;
  localparam int NDN = mcst_pkg::ND_STEPS;

  // Global advance: the pipe moves whenever the output register can take a result
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- Stage 1: scale velocities by the step ----------------
  logic signed [21:0] dts;
  logic signed [53:0] m_wax, m_way, m_wbx, m_wby;
  assign dts   = $signed({1'b0, step_time});
  assign m_wax = vel_a_x * dts;
  assign m_way = vel_a_y * dts;
  assign m_wbx = vel_b_x * dts;
  assign m_wby = vel_b_y * dts;

  logic            v1;
  mcst_pkg::geom_t s1_g;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_g.pax <= pos_a_x;
      s1_g.pay <= pos_a_y;
      s1_g.pbx <= pos_b_x;
      s1_g.pby <= pos_b_y;
      s1_g.vax <= mcst_pkg::sat32(64'(m_wax >>> 16));
      s1_g.vay <= mcst_pkg::sat32(64'(m_way >>> 16));
      s1_g.vbx <= mcst_pkg::sat32(64'(m_wbx >>> 16));
      s1_g.vby <= mcst_pkg::sat32(64'(m_wby >>> 16));
      s1_g.ra  <= radius_a;
      s1_g.rab <= 32'(radius_a) + 32'(radius_b);
    end
  end

  // ---------------- Stage 2: offset and relative velocity ----------------
  logic               v2;
  mcst_pkg::geom_t    s2_g;
  logic signed [31:0] s2_abx, s2_aby, s2_vabx, s2_vaby;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_g    <= s1_g;
      s2_abx  <= mcst_pkg::sat32(64'(s1_g.pbx) - 64'(s1_g.pax));
      s2_aby  <= mcst_pkg::sat32(64'(s1_g.pby) - 64'(s1_g.pay));
      s2_vabx <= mcst_pkg::sat32(64'(s1_g.vbx) - 64'(s1_g.vax));
      s2_vaby <= mcst_pkg::sat32(64'(s1_g.vby) - 64'(s1_g.vay));
    end
  end

  // ---------------- Stage 3: quadratic products ----------------
  logic               v3;
  mcst_pkg::geom_t    s3_g;
  logic signed [63:0] s3_vxx, s3_vyy, s3_hx, s3_hy, s3_axx, s3_ayy;
  logic [63:0]        s3_rr;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_g   <= s2_g;
      s3_vxx <= s2_vabx * s2_vabx;
      s3_vyy <= s2_vaby * s2_vaby;
      s3_hx  <= s2_vabx * s2_abx;
      s3_hy  <= s2_vaby * s2_aby;
      s3_axx <= s2_abx * s2_abx;
      s3_ayy <= s2_aby * s2_aby;
      s3_rr  <= s2_g.rab * s2_g.rab;
    end
  end

  // ---------------- Stage 4: coefficient sums ----------------
  logic signed [64:0] hsum;
  assign hsum = 65'(s3_hx) + 65'(s3_hy);

  logic              v4;
  mcst_pkg::hcar_t   s4_c;
  logic [63:0]       s4_ab2, s4_rr;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_c.g    <= s3_g;
      s4_c.a    <= $unsigned(s3_vxx) + $unsigned(s3_vyy);
      s4_c.hneg <= hsum[64];
      s4_c.hmag <= hsum[64] ? 64'(-hsum) : 64'(hsum);
      s4_c.ge   <= 1'b0;
      s4_c.hit  <= 1'b0;
      s4_ab2    <= $unsigned(s3_axx) + $unsigned(s3_ayy);
      s4_rr     <= s3_rr;
    end
  end

  // ---------------- Stage 5: c sign and magnitude ----------------
  logic            v5;
  mcst_pkg::hcar_t s5_c;
  logic [63:0]     s5_dd;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_c.g    <= s4_c.g;
      s5_c.a    <= s4_c.a;
      s5_c.hneg <= s4_c.hneg;
      s5_c.hmag <= s4_c.hmag;
      s5_c.hit  <= s4_c.hit;
      s5_c.ge   <= s4_ab2 >= s4_rr;
      s5_dd     <= (s4_ab2 >= s4_rr) ? s4_ab2 - s4_rr : s4_rr - s4_ab2;
    end
  end

  // ---------------- Stage 6: partial products of h^2 and a*c ----------------
  logic            v6;
  mcst_pkg::hcar_t s6_c;
  logic [63:0]     s6_hll, s6_hlh, s6_hhh, s6_all, s6_alh, s6_ahl, s6_ahh;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_c   <= s5_c;
      s6_hll <= s5_c.hmag[31:0]  * s5_c.hmag[31:0];
      s6_hlh <= s5_c.hmag[31:0]  * s5_c.hmag[63:32];
      s6_hhh <= s5_c.hmag[63:32] * s5_c.hmag[63:32];
      s6_all <= s5_c.a[31:0]  * s5_dd[31:0];
      s6_alh <= s5_c.a[31:0]  * s5_dd[63:32];
      s6_ahl <= s5_c.a[63:32] * s5_dd[31:0];
      s6_ahh <= s5_c.a[63:32] * s5_dd[63:32];
    end
  end

  // ---------------- Stage 7: combine wide products ----------------
  logic            v7;
  mcst_pkg::hcar_t s7_c;
  logic [127:0]    s7_hsq, s7_ac;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_c   <= s6_c;
      s7_hsq <= {s6_hhh, 64'b0} + (128'(s6_hlh) << 33) + 128'(s6_hll);
      s7_ac  <= {s6_ahh, 64'b0} + (128'(s6_alh) << 32) + (128'(s6_ahl) << 32)
                + 128'(s6_all);
    end
  end

  // ---------------- Stage 8: discriminant, loads the root section ----------------
  logic            q1_v    [0:Q1N];
  mcst_pkg::hcar_t q1_c    [0:Q1N];
  logic [127:0]    q1_x    [0:Q1N];
  logic [64:0]     q1_rem  [0:Q1N];
  logic [63:0]     q1_root [0:Q1N];

  logic miss;
  assign miss = s7_c.ge && (s7_hsq < s7_ac);

  always_ff @(posedge clk) begin
    if (rst) q1_v[0] <= 1'b0;
    else if (en) q1_v[0] <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q1_c[0].g    <= s7_c.g;
      q1_c[0].a    <= s7_c.a;
      q1_c[0].hneg <= s7_c.hneg;
      q1_c[0].hmag <= s7_c.hmag;
      q1_c[0].ge   <= s7_c.ge;
      q1_c[0].hit  <= !miss;
      q1_x[0]      <= s7_c.ge ? s7_hsq - s7_ac : s7_hsq + s7_ac;
      q1_rem[0]    <= '0;
      q1_root[0]   <= '0;
    end
  end

  // ---------------- Discriminant root: one bit per stage ----------------
  for (genvar k = 0; k < Q1N; k++) begin : g_sq1
    logic [65:0] remsh, trial;
    logic        take;
    always_comb begin
      remsh = {q1_rem[k][63:0], q1_x[k][127:126]};
      trial = {1'b0, q1_root[k][62:0], 2'b01};
      take  = remsh >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) q1_v[k+1] <= 1'b0;
      else if (en) q1_v[k+1] <= q1_v[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q1_c[k+1]    <= q1_c[k];
        q1_x[k+1]    <= q1_x[k] << 2;
        q1_rem[k+1]  <= take ? 65'(remsh - trial) : 65'(remsh);
        q1_root[k+1] <= {q1_root[k][62:0], take};
      end
    end
  end

  // ---------------- T1: numerator of the earlier root ----------------
  logic            t1_v, t1_hit;
  mcst_pkg::geom_t t1_g;
  logic [63:0]     t1_n, t1_a;
  logic            tcond;
  assign tcond = q1_c[Q1N].hneg && (q1_c[Q1N].hmag > q1_root[Q1N]) && (q1_c[Q1N].a != '0);

  always_ff @(posedge clk) begin
    if (rst) t1_v <= 1'b0;
    else if (en) t1_v <= q1_v[Q1N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      t1_g   <= q1_c[Q1N].g;
      t1_hit <= q1_c[Q1N].hit;
      t1_n   <= tcond ? q1_c[Q1N].hmag - q1_root[Q1N] : '0;
      t1_a   <= tcond ? q1_c[Q1N].a : 64'd1;
    end
  end

  // ---------------- T2: overflow check, loads the time divider ----------------
  logic            d_v   [0:TDN];
  mcst_pkg::dcar_t d_c   [0:TDN];
  logic [63:0]     d_rem [0:TDN];
  logic [30:0]     d_w   [0:TDN];
  logic [30:0]     d_q   [0:TDN];

  always_ff @(posedge clk) begin
    if (rst) d_v[0] <= 1'b0;
    else if (en) d_v[0] <= t1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_c[0].g   <= t1_g;
      d_c[0].a   <= t1_a;
      d_c[0].hit <= t1_hit;
      d_c[0].ovf <= {15'b0, t1_n} >= {t1_a, 15'b0};
      d_rem[0]   <= t1_n >> 15;
      d_w[0]     <= {t1_n[14:0], 16'b0};
      d_q[0]     <= '0;
    end
  end

  // ---------------- Time divider: one quotient bit per stage ----------------
  for (genvar k = 0; k < TDN; k++) begin : g_td
    logic [64:0] rs;
    logic        take;
    always_comb begin
      rs   = {d_rem[k], d_w[k][30]};
      take = rs >= {1'b0, d_c[k].a};
    end
    always_ff @(posedge clk) begin
      if (rst) d_v[k+1] <= 1'b0;
      else if (en) d_v[k+1] <= d_v[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_c[k+1]   <= d_c[k];
        d_rem[k+1] <= take ? 64'(rs - {1'b0, d_c[k].a}) : 64'(rs);
        d_w[k+1]   <= d_w[k] << 1;
        d_q[k+1]   <= {d_q[k][29:0], take};
      end
    end
  end

  // ---------------- M1: motion products at impact time ----------------
  logic [30:0]        tq;
  logic signed [31:0] tqs;
  assign tq  = d_c[TDN].ovf ? 31'h7fffffff : d_q[TDN];
  assign tqs = $signed({1'b0, tq});

  logic               m1_v, m1_hit;
  mcst_pkg::geom_t    m1_g;
  logic [30:0]        m1_t;
  logic signed [63:0] m1_pax, m1_pay, m1_pbx, m1_pby;
  always_ff @(posedge clk) begin
    if (rst) m1_v <= 1'b0;
    else if (en) m1_v <= d_v[TDN];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m1_g   <= d_c[TDN].g;
      m1_hit <= d_c[TDN].hit;
      m1_t   <= tq;
      m1_pax <= d_c[TDN].g.vax * tqs;
      m1_pay <= d_c[TDN].g.vay * tqs;
      m1_pbx <= d_c[TDN].g.vbx * tqs;
      m1_pby <= d_c[TDN].g.vby * tqs;
    end
  end

  // ---------------- M2: moved centres ----------------
  logic               m2_v, m2_hit;
  logic [30:0]        m2_t, m2_ra;
  logic [31:0]        m2_rab;
  logic signed [31:0] m2_qax, m2_qay, m2_qbx, m2_qby;
  always_ff @(posedge clk) begin
    if (rst) m2_v <= 1'b0;
    else if (en) m2_v <= m1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m2_hit <= m1_hit;
      m2_t   <= m1_t;
      m2_ra  <= m1_g.ra;
      m2_rab <= m1_g.rab;
      m2_qax <= mcst_pkg::sat32(64'(m1_g.pax) + (m1_pax >>> 16));
      m2_qay <= mcst_pkg::sat32(64'(m1_g.pay) + (m1_pay >>> 16));
      m2_qbx <= mcst_pkg::sat32(64'(m1_g.pbx) + (m1_pbx >>> 16));
      m2_qby <= mcst_pkg::sat32(64'(m1_g.pby) + (m1_pby >>> 16));
    end
  end

  // ---------------- M3: centre difference ----------------
  logic               m3_v, m3_hit;
  logic [30:0]        m3_t, m3_ra;
  logic [31:0]        m3_rab;
  logic signed [31:0] m3_qax, m3_qay;
  logic signed [32:0] m3_dx, m3_dy;
  always_ff @(posedge clk) begin
    if (rst) m3_v <= 1'b0;
    else if (en) m3_v <= m2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m3_hit <= m2_hit;
      m3_t   <= m2_t;
      m3_ra  <= m2_ra;
      m3_rab <= m2_rab;
      m3_qax <= m2_qax;
      m3_qay <= m2_qay;
      m3_dx  <= 33'(m2_qbx) - 33'(m2_qax);
      m3_dy  <= 33'(m2_qby) - 33'(m2_qay);
    end
  end

  // ---------------- M4: contact numerators and squared length terms ----------------
  logic [32:0] adx, ady;
  logic        rz;
  assign adx = m3_dx[32] ? 33'(-m3_dx) : 33'(m3_dx);
  assign ady = m3_dy[32] ? 33'(-m3_dy) : 33'(m3_dy);
  assign rz  = (m3_rab == '0);

  logic          m4_v;
  mcst_pkg::ccar_t m4_c;
  logic [63:0]   m4_numx, m4_numy;
  logic [65:0]   m4_sqx, m4_sqy;
  always_ff @(posedge clk) begin
    if (rst) m4_v <= 1'b0;
    else if (en) m4_v <= m3_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m4_c.qax   <= m3_qax;
      m4_c.qay   <= m3_qay;
      m4_c.negx  <= m3_dx[32];
      m4_c.negy  <= m3_dy[32];
      m4_c.nnegx <= !m3_dx[32] && (m3_dx != '0);
      m4_c.nnegy <= !m3_dy[32] && (m3_dy != '0);
      m4_c.mx    <= adx;
      m4_c.my    <= ady;
      m4_c.den   <= rz ? 32'd2 : m3_rab;
      m4_c.t     <= m3_t;
      m4_c.hit   <= m3_hit;
      m4_numx    <= rz ? 64'(adx) : m3_ra * adx;
      m4_numy    <= rz ? 64'(ady) : m3_ra * ady;
      m4_sqx     <= adx * adx;
      m4_sqy     <= ady * ady;
    end
  end

  // ---------------- M5: loads the contact divider and length root ----------------
  logic            c_v     [0:CSN];
  mcst_pkg::ccar_t c_c     [0:CSN];
  logic [31:0]     c_rx    [0:CSN];
  logic [31:0]     c_ry    [0:CSN];
  logic [32:0]     c_wx    [0:CSN];
  logic [32:0]     c_wy    [0:CSN];
  logic [32:0]     c_qx    [0:CSN];
  logic [32:0]     c_qy    [0:CSN];
  logic [65:0]     c_lx    [0:CSN];
  logic [33:0]     c_lrem  [0:CSN];
  logic [32:0]     c_lroot [0:CSN];

  always_ff @(posedge clk) begin
    if (rst) c_v[0] <= 1'b0;
    else if (en) c_v[0] <= m4_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_c[0]     <= m4_c;
      c_rx[0]    <= 32'(m4_numx >> 33);
      c_ry[0]    <= 32'(m4_numy >> 33);
      c_wx[0]    <= m4_numx[32:0];
      c_wy[0]    <= m4_numy[32:0];
      c_qx[0]    <= '0;
      c_qy[0]    <= '0;
      c_lx[0]    <= m4_sqx + m4_sqy;
      c_lrem[0]  <= '0;
      c_lroot[0] <= '0;
    end
  end

  // ---------------- Contact dividers and length root, side by side ----------------
  for (genvar k = 0; k < CSN; k++) begin : g_cs
    logic [32:0] rsx, rsy, dn;
    logic        tx, ty;
    logic [34:0] lsh, ltr;
    logic        lt;
    always_comb begin
      dn  = {1'b0, c_c[k].den};
      rsx = {c_rx[k], c_wx[k][32]};
      rsy = {c_ry[k], c_wy[k][32]};
      tx  = rsx >= dn;
      ty  = rsy >= dn;
      lsh = {c_lrem[k][32:0], c_lx[k][65:64]};
      ltr = {1'b0, c_lroot[k][31:0], 2'b01};
      lt  = lsh >= ltr;
    end
    always_ff @(posedge clk) begin
      if (rst) c_v[k+1] <= 1'b0;
      else if (en) c_v[k+1] <= c_v[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c_c[k+1]     <= c_c[k];
        c_rx[k+1]    <= tx ? 32'(rsx - dn) : 32'(rsx);
        c_ry[k+1]    <= ty ? 32'(rsy - dn) : 32'(rsy);
        c_wx[k+1]    <= c_wx[k] << 1;
        c_wy[k+1]    <= c_wy[k] << 1;
        c_qx[k+1]    <= {c_qx[k][31:0], tx};
        c_qy[k+1]    <= {c_qy[k][31:0], ty};
        c_lx[k+1]    <= c_lx[k] << 2;
        c_lrem[k+1]  <= lt ? 34'(lsh - ltr) : 34'(lsh);
        c_lroot[k+1] <= {c_lroot[k][31:0], lt};
      end
    end
  end

  // ---------------- P: contact point, loads the normal divider ----------------
  logic            n_v   [0:NDN];
  mcst_pkg::ncar_t n_c   [0:NDN];
  logic [32:0]     n_rx  [0:NDN];
  logic [32:0]     n_ry  [0:NDN];
  logic [16:0]     n_wx  [0:NDN];
  logic [16:0]     n_wy  [0:NDN];
  logic [16:0]     n_qx  [0:NDN];
  logic [16:0]     n_qy  [0:NDN];

  logic [32:0] len;
  logic        lz;
  logic signed [63:0] offx, offy;
  assign len  = c_lroot[CSN];
  assign lz   = (len == '0);
  assign offx = c_c[CSN].negx ? -64'(c_qx[CSN]) : 64'(c_qx[CSN]);
  assign offy = c_c[CSN].negy ? -64'(c_qy[CSN]) : 64'(c_qy[CSN]);

  always_ff @(posedge clk) begin
    if (rst) n_v[0] <= 1'b0;
    else if (en) n_v[0] <= c_v[CSN];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n_c[0].cx    <= mcst_pkg::sat32(64'(c_c[CSN].qax) + offx);
      n_c[0].cy    <= mcst_pkg::sat32(64'(c_c[CSN].qay) + offy);
      n_c[0].nnegx <= c_c[CSN].nnegx;
      n_c[0].nnegy <= c_c[CSN].nnegy;
      n_c[0].den   <= lz ? 33'd1 : len;
      n_c[0].t     <= c_c[CSN].t;
      n_c[0].hit   <= c_c[CSN].hit;
      n_rx[0]      <= lz ? '0 : (c_c[CSN].mx >> 1);
      n_ry[0]      <= lz ? '0 : (c_c[CSN].my >> 1);
      n_wx[0]      <= lz ? '0 : {c_c[CSN].mx[0], 16'b0};
      n_wy[0]      <= lz ? '0 : {c_c[CSN].my[0], 16'b0};
      n_qx[0]      <= '0;
      n_qy[0]      <= '0;
    end
  end

  // ---------------- Normal dividers: one quotient bit per stage ----------------
  for (genvar k = 0; k < NDN; k++) begin : g_nd
    logic [33:0] rsx, rsy, dn;
    logic        tx, ty;
    always_comb begin
      dn  = {1'b0, n_c[k].den};
      rsx = {n_rx[k], n_wx[k][16]};
      rsy = {n_ry[k], n_wy[k][16]};
      tx  = rsx >= dn;
      ty  = rsy >= dn;
    end
    always_ff @(posedge clk) begin
      if (rst) n_v[k+1] <= 1'b0;
      else if (en) n_v[k+1] <= n_v[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_c[k+1]  <= n_c[k];
        n_rx[k+1] <= tx ? 33'(rsx - dn) : 33'(rsx);
        n_ry[k+1] <= ty ? 33'(rsy - dn) : 33'(rsy);
        n_wx[k+1] <= n_wx[k] << 1;
        n_wy[k+1] <= n_wy[k] << 1;
        n_qx[k+1] <= {n_qx[k][15:0], tx};
        n_qy[k+1] <= {n_qy[k][15:0], ty};
      end
    end
  end

  // ---------------- Output register: signs applied, miss forces zeros ----------------
  logic signed [17:0] nxv, nyv;
  logic               rhit;
  assign nxv  = n_c[NDN].nnegx ? -$signed(18'(n_qx[NDN])) : $signed(18'(n_qx[NDN]));
  assign nyv  = n_c[NDN].nnegy ? -$signed(18'(n_qy[NDN])) : $signed(18'(n_qy[NDN]));
  assign rhit = n_c[NDN].hit;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= n_v[NDN];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      hit         <= rhit;
      impact_time <= rhit ? n_c[NDN].t : '0;
      contact_x   <= rhit ? n_c[NDN].cx : '0;
      contact_y   <= rhit ? n_c[NDN].cy : '0;
      normal_x    <= rhit ? nxv : '0;
      normal_y    <= rhit ? nyv : '0;
    end
  end

  // ---------------- Assertions ----------------
  // A miss reports every field as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> impact_time == '0 && contact_x == '0 && contact_y == '0
                          && normal_x == '0 && normal_y == '0)
    else $error("miss result carries nonzero fields");

  // Normal components stay within one unit
  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x >= -18'sd65536 && normal_x <= 18'sd65536
                  && normal_y >= -18'sd65536 && normal_y <= 18'sd65536)
    else $error("normal component out of range");

  // The time divider is only loaded with a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    d_v[0] |-> d_c[0].a != '0)
    else $error("time divider loaded with zero divisor");

  // Nothing leaves the pipe in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
